// ===== hdl/emsp_pkg.sv =====
`default_nettype none
package emsp_pkg;

   localparam int POS_W      = 32;
   localparam int EXT_W      = 66;
   localparam int DIST_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = POS_W;
   localparam int SPAN_W     = 7;
   localparam int SQ_W       = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_START     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRAWL     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WARM      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERSHOOT = 3'd5;

   localparam logic [1:0] DIR_IDLE = 2'd0;
   localparam logic [1:0] DIR_CW   = 2'd1;
   localparam logic [1:0] DIR_CCW  = 2'd2;

   localparam logic [1:0] REASON_RUN    = 2'd0;
   localparam logic [1:0] REASON_TARGET = 2'd1;
   localparam logic [1:0] REASON_LIMIT  = 2'd2;
   localparam logic [1:0] REASON_THERE  = 2'd3;

   localparam logic [7:0] BASE_DUTY  = 8'd190;
   localparam logic [7:0] CRAWL_MIN  = 8'd160;
   localparam logic [7:0] CRAWL_MAX  = 8'd210;
   localparam logic [7:0] CRAWL_DROP_NEAR  = 8'd8;
   localparam logic [7:0] CRAWL_DROP_CLOSE = 8'd15;
   localparam logic [7:0] CRAWL_DROP_TIGHT = 8'd20;

   localparam logic [DIST_W-1:0] THERE_DIST   = 32'd5;
   localparam logic [DIST_W-1:0] ARRIVE_DIST  = 32'd2;
   localparam logic [DIST_W-1:0] CRAWL_ZONE   = 32'd100;
   localparam logic [DIST_W-1:0] NEAR_ZONE    = 32'd50;
   localparam logic [DIST_W-1:0] CLOSE_ZONE   = 32'd20;
   localparam logic [DIST_W-1:0] TIGHT_ZONE   = 32'd10;

   typedef enum logic [1:0] {
      JOB_DONE,
      JOB_RAMP,
      JOB_CRUISE,
      JOB_DECEL
   } job_kind_type;

   typedef struct packed {
      logic signed [POS_W-1:0] current_position;
      logic                    limit_cw_level;
      logic                    limit_ccw_level;
   } req_type;

   typedef struct packed {
      logic [7:0] pwm_duty;
      logic [1:0] drive_direction;
      logic       move_done;
      logic [1:0] end_reason;
   } rsp_type;

   typedef struct packed {
      logic                    dist_small;
      logic                    cw;
      logic signed [POS_W-1:0] start;
      logic signed [63:0]      comp;
      logic [DIST_W-1:0]       accel;
      logic [DIST_W-1:0]       decel;
      logic [7:0]              max_duty;
      logic [SPAN_W-1:0]       span;
      logic [SQ_W-1:0]         span_sq;
      logic [7:0]              crawl;
   } profile_type;

   typedef struct packed {
      job_kind_type      kind;
      logic [1:0]        reason;
      logic [DIST_W-1:0] moved;
      logic [DIST_W-1:0] togo;
   } job_type;

   function automatic logic [DIST_W-1:0] absdiff_sat(input logic signed [EXT_W-1:0] a,
                                                     input logic signed [EXT_W-1:0] b);
      logic signed [EXT_W:0] d;
      logic [EXT_W:0]        m;
      logic [DIST_W-1:0]     r;
      d = $signed({a[EXT_W-1], a}) - $signed({b[EXT_W-1], b});
      m = d[EXT_W] ? $unsigned(-d) : $unsigned(d);
      r = (m[EXT_W:DIST_W] != '0) ? '1 : m[DIST_W-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/encoder_move_speed_profile.sv =====
// Channel   Handshake            Payload
// request   start / busy         req_data  (req_type)
// result    rsp_valid strobe     rsp_data  (rsp_type)
// csr       csr_write            csr_index, csr_wdata
//
// One transaction per cycle while busy is low; rsp_valid follows the front,
// queue, stage and result registers. busy stays high after reset and each csr
// write, while reciprocal multiplies derive distance, zones, overshoot target.
// Per sample the ramp quotient and decel root resolve one bit per stage (7).
// Reset is synchronous and active high. The result side cannot stall.
`default_nettype none
module encoder_move_speed_profile import emsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   profile_type profile;
   logic        accept;
   logic        push, q_valid;
   job_type     push_job, q_job;

   assign accept = start && !busy;

   emsp_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .profile   (profile)
   );

   emsp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .profile  (profile),
      .push     (push),
      .push_job (push_job)
   );

   emsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (q_valid),
      .valid    (q_valid),
      .pop_job  (q_job)
   );

   emsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job       (q_job),
      .profile   (profile),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.move_done |->
         rsp_data.pwm_duty == 8'd0 && rsp_data.drive_direction == DIR_IDLE)
      else $error("finished move still driving");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.move_done |->
         rsp_data.pwm_duty >= CRAWL_MIN && rsp_data.end_reason == REASON_RUN
         && rsp_data.drive_direction != DIR_IDLE)
      else $error("running result malformed");

   assert property (@(posedge clock) reset |=> busy)
      else $error("profile not rederived after reset");

endmodule
`default_nettype wire

// ===== hdl/emsp_setup.sv =====
`default_nettype none
module emsp_setup import emsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  busy,
   output profile_type           profile
);

   localparam int PRED_SHIFT = 7;
   localparam logic [DIST_W-1:0] PRED_DIVISOR = 32'd48000;
   localparam logic [DIST_W-1:0] ZONE_DIVISOR = 32'd5;
   // floor(x/375) = (x * RECIP_375) >> 34 for 25-bit x
   localparam logic [25:0] RECIP_375 = 26'd45812985;
   // floor(x/5) = (x * RECIP_5) >> 34 for 32-bit x
   localparam logic [31:0] RECIP_5   = 32'hCCCC_CCCD;
   localparam logic signed [EXT_W-1:0] I64_MAX = {{(EXT_W-63){1'b0}}, {63{1'b1}}};
   localparam logic signed [EXT_W-1:0] I64_MIN = {{(EXT_W-63){1'b1}}, 63'd0};
   localparam logic signed [9:0] CRAWL_BASE = 10'sd165;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_SPLIT, ST_REM, ST_PROD, ST_PRED, ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic signed [POS_W-1:0] start_ff, start_in, target_ff, target_in;
   logic [7:0]              max_ff, max_in;
   logic [6:0]              crawl_ff, crawl_in;
   logic                    warm_ff, warm_in;
   logic [15:0]             ovs_ff, ovs_in;
   logic [DIST_W-1:0]       dist_ff, dist_in;
   logic                    cw_ff, cw_in;
   logic [DIST_W-1:0]       q5_ff, q5_in;
   logic [16:0]             blk_ff, blk_in;
   logic [2:0]              rem5_ff, rem5_in;
   logic [15:0]             frac_ff, frac_in;
   logic [DIST_W-1:0]       whole_ff, whole_in, prod_ff, prod_in;
   logic [DIST_W-1:0]       pmag_ff, pmag_in, accel_ff, accel_in, decel_ff, decel_in;
   profile_type             profile_ff, profile_in;

   logic [DIST_W-1:0]       div_arg;
   logic [50:0]             recip_prod;
   logic [16:0]             div48;
   logic [63:0]             fifth_prod;
   logic [DIST_W-1:0]       whole_lo, fifth_lo;
   logic [1:0]              third;
   logic [15:0]             ovs_mag;
   logic signed [EXT_W-1:0] start_ext, target_ext, adj, sum, comp_ext;
   logic [7:0]              max_duty;
   logic [SPAN_W-1:0]       span;
   logic [2*SPAN_W-1:0]     span_sq;
   logic signed [9:0]       crawl_sum;

   always_comb begin
      start_ext  = {{(EXT_W-POS_W){start_ff[POS_W-1]}}, start_ff};
      target_ext = {{(EXT_W-POS_W){target_ff[POS_W-1]}}, target_ff};
      // dist = blk * 48000 + frac, so |ovs| * dist / 48000 = |ovs| * blk + |ovs| * frac / 48000
      div_arg    = (state_ff == ST_PRED) ? prod_ff : dist_ff;
      recip_prod = 51'(div_arg[DIST_W-1:PRED_SHIFT]) * 51'(RECIP_375);
      div48      = recip_prod[50:34];
      fifth_prod = 64'(dist_ff) * 64'(RECIP_5);
      whole_lo   = dist_ff - (DIST_W'(blk_ff) * PRED_DIVISOR);
      fifth_lo   = dist_ff - (q5_ff * ZONE_DIVISOR);
      third      = (rem5_ff >= 3'd4) ? 2'd2 : ((rem5_ff >= 3'd2) ? 2'd1 : 2'd0);
      ovs_mag    = ovs_ff[15] ? (~ovs_ff + 16'd1) : ovs_ff;
      adj        = EXT_W'(pmag_ff);
      sum        = (cw_ff ^ ovs_ff[15]) ? (target_ext - adj) : (target_ext + adj);
      if ((pmag_ff > 32'd5) && (dist_ff > 32'd500)) begin
         comp_ext = (sum > I64_MAX) ? I64_MAX : ((sum < I64_MIN) ? I64_MIN : sum);
      end else begin
         comp_ext = target_ext;
      end
      max_duty  = (max_ff < BASE_DUTY) ? BASE_DUTY : max_ff;
      span      = SPAN_W'(max_duty - BASE_DUTY);
      span_sq   = span * span;
      crawl_sum = CRAWL_BASE + $signed({{3{crawl_ff[6]}}, crawl_ff})
                  + (warm_ff ? 10'sd8 : 10'sd0)
                  + ((dist_ff > 32'd5100) ? 10'sd5 : 10'sd0);

      state_in   = state_ff;
      start_in   = start_ff;
      target_in  = target_ff;
      max_in     = max_ff;
      crawl_in   = crawl_ff;
      warm_in    = warm_ff;
      ovs_in     = ovs_ff;
      dist_in    = dist_ff;
      cw_in      = cw_ff;
      q5_in      = q5_ff;
      blk_in     = blk_ff;
      rem5_in    = rem5_ff;
      frac_in    = frac_ff;
      whole_in   = whole_ff;
      prod_in    = prod_ff;
      pmag_in    = pmag_ff;
      accel_in   = accel_ff;
      decel_in   = decel_ff;
      profile_in = profile_ff;

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_PREP: begin
            dist_in  = absdiff_sat(target_ext, start_ext);
            cw_in    = target_ff > start_ff;
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            q5_in    = {2'b00, fifth_prod[63:34]};
            blk_in   = div48;
            state_in = ST_REM;
         end
         ST_REM: begin
            rem5_in  = fifth_lo[2:0];
            frac_in  = whole_lo[15:0];
            accel_in = q5_ff;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            whole_in = DIST_W'(ovs_mag) * DIST_W'(blk_ff);
            prod_in  = DIST_W'(ovs_mag) * DIST_W'(frac_ff);
            // floor(3 * dist / 5) = 3 * q + floor(3 * r / 5)
            decel_in = (q5_ff << 1) + q5_ff + DIST_W'(third);
            state_in = ST_PRED;
         end
         ST_PRED: begin
            pmag_in  = whole_ff + DIST_W'(div48);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            profile_in.dist_small = dist_ff < THERE_DIST;
            profile_in.cw         = cw_ff;
            profile_in.start      = start_ff;
            profile_in.comp       = comp_ext[63:0];
            profile_in.accel      = accel_ff;
            profile_in.decel      = decel_ff;
            profile_in.max_duty   = max_duty;
            profile_in.span       = span;
            profile_in.span_sq    = span_sq[SQ_W-1:0];
            profile_in.crawl      = (crawl_sum < 10'sd160) ? CRAWL_MIN : crawl_sum[7:0];
            state_in              = ST_IDLE;
         end
         default: state_in = ST_PREP;
      endcase

      if (csr_write) begin
         state_in = ST_PREP;
         unique case (csr_index)
            CSR_START:     start_in  = csr_wdata[POS_W-1:0];
            CSR_TARGET:    target_in = csr_wdata[POS_W-1:0];
            CSR_MAX_SPEED: max_in    = csr_wdata[7:0];
            CSR_CRAWL:     crawl_in  = csr_wdata[6:0];
            CSR_WARM:      warm_in   = csr_wdata[0];
            CSR_OVERSHOOT: ovs_in    = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_PREP;
         start_ff  <= '0;
         target_ff <= '0;
         max_ff    <= 8'd250;
         crawl_ff  <= '0;
         warm_ff   <= 1'b0;
         ovs_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         start_ff  <= start_in;
         target_ff <= target_in;
         max_ff    <= max_in;
         crawl_ff  <= crawl_in;
         warm_ff   <= warm_in;
         ovs_ff    <= ovs_in;
      end
      dist_ff    <= dist_in;
      cw_ff      <= cw_in;
      q5_ff      <= q5_in;
      blk_ff     <= blk_in;
      rem5_ff    <= rem5_in;
      frac_ff    <= frac_in;
      whole_ff   <= whole_in;
      prod_ff    <= prod_in;
      pmag_ff    <= pmag_in;
      accel_ff   <= accel_in;
      decel_ff   <= decel_in;
      profile_ff <= profile_in;
   end

   assign busy    = state_ff != ST_IDLE;
   assign profile = profile_ff;

endmodule
`default_nettype wire

// ===== hdl/emsp_front.sv =====
`default_nettype none
module emsp_front import emsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   input  profile_type profile,
   output logic        push,
   output job_type     push_job
);

   logic                    valid_ff;
   req_type                 req_ff;
   logic                    push_ff;
   job_type                 job_ff, job_in;

   logic signed [EXT_W-1:0] cur_ext, start_ext, comp_ext;
   logic                    reached, limit_hit;
   logic [DIST_W-1:0]       moved, togo;

   always_comb begin
      cur_ext   = {{(EXT_W-POS_W){req_ff.current_position[POS_W-1]}}, req_ff.current_position};
      start_ext = {{(EXT_W-POS_W){profile.start[POS_W-1]}}, profile.start};
      comp_ext  = {{(EXT_W-64){profile.comp[63]}}, profile.comp};
      moved     = absdiff_sat(cur_ext, start_ext);
      togo      = absdiff_sat(comp_ext, cur_ext);
      reached   = profile.cw ? (cur_ext >= comp_ext) : (cur_ext <= comp_ext);
      limit_hit = profile.cw ? req_ff.limit_cw_level : req_ff.limit_ccw_level;

      job_in.moved  = moved;
      job_in.togo   = togo;
      job_in.reason = REASON_RUN;
      if (profile.dist_small) begin
         job_in.kind   = JOB_DONE;
         job_in.reason = REASON_THERE;
      end else if (limit_hit) begin
         job_in.kind   = JOB_DONE;
         job_in.reason = REASON_LIMIT;
      end else if (moved < profile.accel) begin
         job_in.kind = JOB_RAMP;
      end else if (togo > profile.decel) begin
         job_in.kind = JOB_CRUISE;
      end else begin
         job_in.kind = JOB_DECEL;
      end
      if (!profile.dist_small && !limit_hit
          && (reached || (job_in.kind == JOB_DECEL && togo <= ARRIVE_DIST))) begin
         job_in.kind   = JOB_DONE;
         job_in.reason = REASON_TARGET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         push_ff  <= 1'b0;
      end else begin
         valid_ff <= accept;
         push_ff  <= valid_ff;
      end
      req_ff <= req;
      job_ff <= job_in;
   end

   assign push     = push_ff;
   assign push_job = job_ff;

endmodule
`default_nettype wire

// ===== hdl/emsp_queue.sv =====
`default_nettype none
module emsp_queue import emsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    valid,
   output job_type pop_job
);

   localparam int DEPTH = 2;
   localparam int PTR_W = 1;
   localparam int CNT_W = 2;

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   always_comb begin
      do_pop   = pop && (count_ff != '0);
      wr_in    = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + PTR_W'(1) : rd_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

   assign valid   = count_ff != '0;
   assign pop_job = entry_ff[rd_ff];

endmodule
`default_nettype wire

// ===== hdl/emsp_back.sv =====
`default_nettype none
module emsp_back import emsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   input  profile_type profile,
   output logic        rsp_valid,
   output rsp_type     rsp
);

   localparam int NUM_W = DIST_W + SPAN_W;
   localparam int TSQ_W = SQ_W + DIST_W;
   localparam int SQR_W = 2 * SPAN_W;
   localparam int CMP_W = SQR_W + DIST_W;

   typedef struct packed {
      logic              valid;
      job_type           job;
      logic [NUM_W-1:0]  rem;
      logic [SPAN_W-1:0] quo;
      logic [SPAN_W-1:0] root;
      logic [SQR_W-1:0]  root_sq;
      logic [TSQ_W-1:0]  tsq;
   } lane_type;

   lane_type stage_ff [SPAN_W+1];
   lane_type stage_in [SPAN_W+1];
   logic     rsp_valid_ff;
   rsp_type  rsp_ff, rsp_in;

   lane_type          prev, nxt, last;
   logic [NUM_W-1:0]  divsr;
   logic [SPAN_W-1:0] bitm, cand;
   logic [SQR_W-1:0]  cand_sq;
   logic [CMP_W-1:0]  lhs;
   logic [7:0]        crawl_sel, duty;

   always_comb begin
      stage_in[0].valid   = job_valid;
      stage_in[0].job     = job;
      stage_in[0].rem     = NUM_W'(job.moved * profile.span);
      stage_in[0].quo     = '0;
      stage_in[0].root    = '0;
      stage_in[0].root_sq = '0;
      stage_in[0].tsq     = TSQ_W'(job.togo * profile.span_sq);

      for (int i = 1; i <= SPAN_W; i++) begin
         prev    = stage_ff[i-1];
         nxt     = prev;
         bitm    = SPAN_W'(1) << (SPAN_W - i);
         divsr   = NUM_W'(profile.accel) << (SPAN_W - i);
         if (prev.rem >= divsr) begin
            nxt.rem = prev.rem - divsr;
            nxt.quo = prev.quo | bitm;
         end
         cand    = prev.root | bitm;
         cand_sq = prev.root_sq + (SQR_W'(prev.root) << (SPAN_W - i + 1))
                   + (SQR_W'(1) << (2 * (SPAN_W - i)));
         lhs     = CMP_W'(cand_sq) * CMP_W'(profile.decel);
         if ((cand <= profile.span) && (lhs <= CMP_W'(prev.tsq))) begin
            nxt.root    = cand;
            nxt.root_sq = cand_sq;
         end
         stage_in[i] = nxt;
      end

      last = stage_ff[SPAN_W];
      if (last.job.togo < TIGHT_ZONE) begin
         crawl_sel = profile.crawl - CRAWL_DROP_TIGHT;
      end else if (last.job.togo < CLOSE_ZONE) begin
         crawl_sel = profile.crawl - CRAWL_DROP_CLOSE;
      end else if (last.job.togo < NEAR_ZONE) begin
         crawl_sel = profile.crawl - CRAWL_DROP_NEAR;
      end else begin
         crawl_sel = profile.crawl;
      end

      duty = '0;
      case (last.job.kind)
         JOB_RAMP:   duty = BASE_DUTY + 8'(last.quo);
         JOB_CRUISE: duty = profile.max_duty;
         JOB_DECEL: begin
            duty = (last.job.togo < CRAWL_ZONE) ? crawl_sel : BASE_DUTY + 8'(last.root);
            if (duty < CRAWL_MIN) duty = CRAWL_MIN;
            if (duty > CRAWL_MAX) duty = CRAWL_MAX;
         end
         default: duty = '0;
      endcase

      rsp_in.pwm_duty   = duty;
      rsp_in.end_reason = last.job.reason;
      if (last.job.kind == JOB_DONE) begin
         rsp_in.move_done       = 1'b1;
         rsp_in.drive_direction = DIR_IDLE;
      end else begin
         rsp_in.move_done       = 1'b0;
         rsp_in.drive_direction = profile.cw ? DIR_CW : DIR_CCW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= SPAN_W; i++) begin
            stage_ff[i].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_ff     <= stage_in;
         rsp_valid_ff <= last.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
   import emsp_pkg::*;

   localparam longint SAT32     = 64'h0000_0000_FFFF_FFFF;
   localparam int     WDOG_MAX  = 4000;
   localparam int     N_PHASES  = 30;
   localparam int     PHASE_LEN = 64;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;

   encoder_move_speed_profile dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // shadow of the move setup
   logic signed [31:0] mv_start  = 0;
   logic signed [31:0] mv_target = 0;
   logic [7:0]         mv_max    = 8'd250;
   logic [6:0]         mv_crawl  = '0;
   logic               mv_warm   = 1'b0;
   logic [15:0]        mv_ovs    = '0;

   rsp_type tick_q[$];
   int      errors = 0;
   int      n_sent = 0;
   int      n_ticks = 0;
   int      n_reason[4] = '{0, 0, 0, 0};
   int      n_moves = 0;
   int      quiet = 0;
   bit      steady = 1'b0;

   initial forever #5 clock = ~clock;

   function automatic longint gap_sat(longint a, longint b);
      longint d;
      d = (a >= b) ? a - b : b - a;
      return (d > SAT32) ? SAT32 : d;
   endfunction

   function automatic rsp_type profile_tick(req_type r);
      rsp_type o;
      longint  st, tg, cur, travel, pred, comp, maxs, span, accel, decel, moved, togo;
      longint  k, d, crawl;
      bit      cw;
      st     = mv_start;
      tg     = mv_target;
      cur    = r.current_position;
      travel = gap_sat(tg, st);
      o      = '{8'd0, DIR_IDLE, 1'b1, REASON_THERE};
      if (travel < 5) return o;
      cw = tg > st;
      o.end_reason = REASON_LIMIT;
      if ((cw && r.limit_cw_level) || (!cw && r.limit_ccw_level)) return o;
      o.end_reason = REASON_TARGET;
      pred = (longint'($signed(mv_ovs)) * travel) / 48000;
      comp = tg;
      if ((pred > 5 || pred < -5) && travel > 500) comp = cw ? tg - pred : tg + pred;
      maxs  = (mv_max < BASE_DUTY) ? BASE_DUTY : mv_max;
      span  = maxs - BASE_DUTY;
      accel = travel * 2 / 10;
      decel = travel * 6 / 10;
      moved = gap_sat(cur, st);
      togo  = gap_sat(comp, cur);
      if (moved < accel) begin
         d = BASE_DUTY + (moved * span) / accel;
      end else if (togo > decel) begin
         d = maxs;
      end else begin
         k = 0;
         while (k < span && (k + 1) * (k + 1) * decel <= span * span * togo) k++;
         d = BASE_DUTY + k;
         crawl = 165 + longint'($signed(mv_crawl)) + (mv_warm ? 8 : 0)
                 + (travel > 5100 ? 5 : 0);
         if (crawl < CRAWL_MIN) crawl = CRAWL_MIN;
         if (togo < CRAWL_ZONE) d = crawl;
         if (togo < NEAR_ZONE) d = crawl - CRAWL_DROP_NEAR;
         if (togo < CLOSE_ZONE) d = crawl - CRAWL_DROP_CLOSE;
         if (togo < TIGHT_ZONE) d = crawl - CRAWL_DROP_TIGHT;
         if (d < CRAWL_MIN) d = CRAWL_MIN;
         if (d > CRAWL_MAX) d = CRAWL_MAX;
         if (togo <= ARRIVE_DIST) return o;
      end
      if ((cw && cur >= comp) || (!cw && cur <= comp)) return o;
      o.pwm_duty        = d[7:0];
      o.drive_direction = cw ? DIR_CW : DIR_CCW;
      o.move_done       = 1'b0;
      o.end_reason      = REASON_RUN;
      return o;
   endfunction

   // accept monitor, result checker, watchdog
   always @(posedge clock) begin
      rsp_type exp_t;
      if (!reset) begin
         if ((start && !busy) || csr_write || rsp_valid) begin
            quiet = 0;
         end else begin
            quiet = quiet + 1;
         end
         if (start && !busy) begin
            tick_q.push_back(profile_tick(req_data));
         end
         if (rsp_valid) begin
            n_ticks <= n_ticks + 1;
            n_reason[rsp_data.end_reason] <= n_reason[rsp_data.end_reason] + 1;
            if (tick_q.size() == 0) begin
               $error("result with no transaction pending");
               errors++;
            end else begin
               exp_t = tick_q.pop_front();
               if (rsp_data.pwm_duty !== exp_t.pwm_duty) begin
                  $error("pwm_duty exp %0d got %0d", exp_t.pwm_duty, rsp_data.pwm_duty);
                  errors++;
               end
               if (rsp_data.drive_direction !== exp_t.drive_direction) begin
                  $error("drive_direction exp %0d got %0d", exp_t.drive_direction,
                         rsp_data.drive_direction);
                  errors++;
               end
               if (rsp_data.move_done !== exp_t.move_done) begin
                  $error("move_done exp %0d got %0d", exp_t.move_done, rsp_data.move_done);
                  errors++;
               end
               if (rsp_data.end_reason !== exp_t.end_reason) begin
                  $error("end_reason exp %0d got %0d", exp_t.end_reason, rsp_data.end_reason);
                  errors++;
               end
            end
         end
         if (quiet >= WDOG_MAX) begin
            $display("watchdog expired");
            $display("encoder_move_speed_profile verification failed");
            $finish;
         end
      end
   end

   task automatic send_tick(logic signed [31:0] pos, bit lcw, bit lccw);
      @(negedge clock);
      if (!steady && $urandom_range(99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= '{pos, lcw, lccw};
      n_sent++;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      while (tick_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_START:     mv_start  = v;
         CSR_TARGET:    mv_target = v;
         CSR_MAX_SPEED: mv_max    = v[7:0];
         CSR_CRAWL:     mv_crawl  = v[6:0];
         CSR_WARM:      mv_warm   = v[0];
         CSR_OVERSHOOT: mv_ovs    = v[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_move(logic [31:0] st, logic [31:0] tg, logic [7:0] mx,
                           logic [6:0] cr, bit wm, logic [15:0] ov);
      drain();
      write_reg(CSR_START, st);
      write_reg(CSR_TARGET, tg);
      write_reg(CSR_MAX_SPEED, {24'd0, mx});
      write_reg(CSR_CRAWL, {25'd0, cr});
      write_reg(CSR_WARM, {31'd0, wm});
      write_reg(CSR_OVERSHOOT, {16'd0, ov});
      n_moves++;
   endtask

   task automatic test_already_there;
      set_move(100, 103, 8'd250, 7'd0, 1'b0, 16'd0);
      send_tick(100, 1'b0, 1'b0);
      send_tick(-5, 1'b1, 1'b1);
   endtask

   task automatic test_limits;
      set_move(0, 10000, 8'd250, 7'd0, 1'b0, 16'd0);
      send_tick(0, 1'b1, 1'b0);
      send_tick(0, 1'b0, 1'b1);
      set_move(0, -10000, 8'd250, 7'd0, 1'b0, 16'd0);
      send_tick(0, 1'b0, 1'b1);
      send_tick(-100, 1'b1, 1'b0);
   endtask

   task automatic test_profile;
      logic signed [31:0] pts[11] = '{0, 1000, 1999, 3000, 6000, 9950, 9960, 9985, 9995,
                                      9998, 10005};
      set_move(0, 10000, 8'd255, 7'd35, 1'b1, 16'd0);
      foreach (pts[i]) send_tick(pts[i], 1'b0, 1'b0);
   endtask

   task automatic test_extremes;
      set_move(32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 7'h76, 1'b0, 16'h8000);
      send_tick(32'sh8000_0000, 1'b0, 1'b0);
      send_tick(32'sh7FFF_FFFF, 1'b0, 1'b0);
      drain();
      write_reg(CSR_OVERSHOOT, 32'h0000_7FFF);
      write_reg(CSR_OVERSHOOT + 3'd2, 32'hFFFF_FFFF);
      send_tick(32'sh4000_0000, 1'b0, 1'b0);
      send_tick(32'sh7FFF_0000, 1'b0, 1'b0);
   endtask

   task automatic test_random;
      longint             travel, st, tg, along, cur;
      logic [63:0]        rnd;
      logic [7:0]         mx;
      logic [15:0]        ov;
      int                 sgn, sel;
      for (int p = 0; p < N_PHASES; p++) begin
         steady = (p >= 10 && p < 14);
         sel = $urandom_range(9);
         if (sel == 0) travel = $urandom_range(0, 8);
         else if (sel <= 5) travel = $urandom_range(9, 6000);
         else if (sel <= 7) travel = $urandom_range(6000, 200000);
         else travel = $urandom;
         sgn = $urandom_range(1) ? 1 : -1;
         st  = $signed($urandom);
         tg  = st + sgn * travel;
         case ($urandom_range(5))
            0: mx = 8'd0;
            1: mx = 8'd189;
            2: mx = 8'd190;
            3: mx = 8'd255;
            default: mx = $urandom;
         endcase
         ov = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 800) - 400);
         set_move(st[31:0], tg[31:0], mx, 7'($urandom_range(0, 45) - 10),
                  $urandom_range(1), ov);
         for (int i = 0; i < PHASE_LEN; i++) begin
            rnd = {$urandom, $urandom};
            sel = $urandom_range(9);
            if (sel <= 1) cur = $signed($urandom);
            else if (sel <= 6) begin
               along = longint'(rnd % (travel + 40)) - 20;
               cur = st + sgn * along;
            end else cur = tg + longint'($urandom_range(0, 240)) - 120;
            send_tick(cur[31:0], $urandom_range(99) < 12, $urandom_range(99) < 12);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_already_there();
      test_limits();
      test_profile();
      test_extremes();
      test_random();
      drain();
      $display("%0d ticks over %0d move setups, %0d results checked", n_sent, n_moves, n_ticks);
      $display("running %0d, target %0d, limit %0d, already there %0d",
               n_reason[0], n_reason[1], n_reason[2], n_reason[3]);
      if (errors == 0) begin
         $display("encoder_move_speed_profile verification clean");
      end else begin
         $display("encoder_move_speed_profile verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
